@@ rtl/mdq_pkg.sv @@
// package for the multi deque block: defaults, operation and status codes,
// controller state type and the command and status structs between modules
`timescale 1ns / 1ps

package mdq_pkg;

    localparam int NUM_QUEUES_DEF = 256;
    localparam int POOL_SIZE_DEF  = 4096;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_MERGE = 2'd2;

    localparam logic [1:0] ST_POPPED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PUSH,
        S_POP,
        S_MSRC,
        S_MREV,
        S_MFIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       load_tgt;
        logic       push_wr;
        logic       pop_wr;
        logic       cat_wr;
        logic       rev_start;
        logic       rev_step;
        logic       fin_wr;
        logic       res_load;
        logic [1:0] res_code;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       sel;
        logic       q_ok;
        logic       merge_ok;
        logic       tgt_empty;
        logic       pool_empty;
        logic       src_empty;
        logic       last;
        logic       out_free;
    } t_sts;

endpackage

@@ rtl/mdq_ram.sv @@
// generic single write port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module mdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mdq_ctrl.sv @@
// controller state machine of the multi deque block
// depends on mdq_pkg
`timescale 1ns / 1ps

module mdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mdq_pkg::t_sts i_sts,
    output mdq_pkg::t_cmd o_cmd,
    output logic          o_stall
);

    mdq_pkg::t_state r_state;
    mdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdq_pkg::S_IDLE: begin
                if (i_valid) n_state = mdq_pkg::S_LOAD;
            end
            mdq_pkg::S_LOAD: begin
                case (i_sts.mode)
                    mdq_pkg::MODE_PUSH: begin
                        if (!i_sts.q_ok) n_state = mdq_pkg::S_IDLE;
                        else if (i_sts.pool_empty) n_state = mdq_pkg::S_EMIT;
                        else n_state = mdq_pkg::S_PUSH;
                    end
                    mdq_pkg::MODE_POP: begin
                        if (!i_sts.q_ok || i_sts.tgt_empty) n_state = mdq_pkg::S_EMIT;
                        else n_state = mdq_pkg::S_POP;
                    end
                    mdq_pkg::MODE_MERGE: begin
                        if (i_sts.merge_ok) n_state = mdq_pkg::S_MSRC;
                        else n_state = mdq_pkg::S_IDLE;
                    end
                    default: n_state = mdq_pkg::S_IDLE;
                endcase
            end
            mdq_pkg::S_PUSH: n_state = mdq_pkg::S_IDLE;
            mdq_pkg::S_POP:  n_state = mdq_pkg::S_EMIT;
            mdq_pkg::S_MSRC: begin
                if (i_sts.src_empty || !i_sts.sel) n_state = mdq_pkg::S_IDLE;
                else n_state = mdq_pkg::S_MREV;
            end
            mdq_pkg::S_MREV: begin
                if (i_sts.last) n_state = mdq_pkg::S_MFIN;
            end
            mdq_pkg::S_MFIN: n_state = mdq_pkg::S_IDLE;
            mdq_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = mdq_pkg::S_IDLE;
            end
            default: n_state = mdq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mdq_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            mdq_pkg::S_LOAD: begin
                o_cmd.load_tgt = 1'b1;
                if (i_sts.mode == mdq_pkg::MODE_PUSH && i_sts.q_ok && i_sts.pool_empty) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mdq_pkg::ST_FULL;
                end
                if (i_sts.mode == mdq_pkg::MODE_POP && (!i_sts.q_ok || i_sts.tgt_empty)) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mdq_pkg::ST_EMPTY;
                end
            end
            mdq_pkg::S_PUSH: o_cmd.push_wr = 1'b1;
            mdq_pkg::S_POP: begin
                o_cmd.pop_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = mdq_pkg::ST_POPPED;
            end
            mdq_pkg::S_MSRC: begin
                o_cmd.cat_wr    = !i_sts.src_empty && !i_sts.sel;
                o_cmd.rev_start = !i_sts.src_empty && i_sts.sel;
            end
            mdq_pkg::S_MREV: o_cmd.rev_step = 1'b1;
            mdq_pkg::S_MFIN: o_cmd.fin_wr   = 1'b1;
            mdq_pkg::S_EMIT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/mdq_dp.sv @@
// datapath of the multi deque block: node and queue memories, free list, result register
// depends on mdq_pkg and mdq_ram
`timescale 1ns / 1ps

module mdq_dp #(
    parameter int NUM_QUEUES = mdq_pkg::NUM_QUEUES_DEF,
    parameter int POOL_SIZE  = mdq_pkg::POOL_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mdq_pkg::t_cmd      i_cmd,
    output mdq_pkg::t_sts      o_sts,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_queue_id,
    input  logic               i_end_select,
    input  logic signed [31:0] i_push_value,
    input  logic [7:0]         i_other_queue,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_pop_value
);

    localparam int NA  = $clog2(POOL_SIZE);
    localparam int QA  = $clog2(NUM_QUEUES);
    localparam int CW  = NA + 1;
    localparam int QEW = 2 * NA + CW;

    logic [1:0]      r_mode;
    logic [7:0]      r_q8;
    logic [7:0]      r_o8;
    logic            r_sel;
    logic [31:0]     r_val;
    logic [NA-1:0]   r_dh;
    logic [NA-1:0]   r_dt;
    logic [CW-1:0]   r_dl;
    logic [NA-1:0]   r_node;
    logic [CW-1:0]   r_cnt;
    logic [NA-1:0]   r_free_head;
    logic [CW-1:0]   r_free_count;
    logic [CW-1:0]   r_hwm;
    logic [NUM_QUEUES-1:0] r_vld;
    logic [1:0]      r_res_st;
    logic [31:0]     r_res_val;
    logic            r_ov;
    logic [1:0]      r_ost;
    logic [31:0]     r_oval;

    logic [31:0]     in_q32;
    logic [31:0]     q32;
    logic [31:0]     o32;
    logic [QA-1:0]   tgt_a;
    logic [QA-1:0]   src_a;
    logic            q_ok;
    logic            o_ok;

    logic [QEW-1:0]  q_rd;
    logic [NA-1:0]   rq_head;
    logic [NA-1:0]   rq_tail;
    logic [CW-1:0]   rq_len;
    logic [31:0]     val_rd;
    logic [NA-1:0]   next_rd;
    logic [NA-1:0]   prev_rd;

    logic            q_we;
    logic [QA-1:0]   q_raddr;
    logic [NA-1:0]   wq_head;
    logic [NA-1:0]   wq_tail;
    logic [CW-1:0]   wq_len;
    logic            val_we;
    logic            next_we;
    logic [NA-1:0]   next_wa;
    logic [NA-1:0]   next_wd;
    logic            prev_we;
    logic [NA-1:0]   prev_wa;
    logic [NA-1:0]   prev_wd;
    logic [NA-1:0]   next_ra;
    logic [NA-1:0]   prev_ra;
    logic [NA-1:0]   pop_node;
    logic            fresh;
    logic [NA-1:0]   fresh_next;
    logic [NA-1:0]   take_next;
    logic [CW-1:0]   tgt_len;
    logic [CW-1:0]   src_len;

    assign in_q32 = 32'(i_queue_id);
    assign q32    = 32'(r_q8);
    assign o32    = 32'(r_o8);
    assign tgt_a  = q32[QA-1:0];
    assign src_a  = o32[QA-1:0];
    assign q_ok   = q32 < 32'(NUM_QUEUES);
    assign o_ok   = o32 < 32'(NUM_QUEUES);

    assign rq_head = q_rd[QEW-1 -: NA];
    assign rq_tail = q_rd[CW +: NA];
    assign rq_len  = q_rd[CW-1:0];
    assign tgt_len = r_vld[tgt_a] ? rq_len : '0;
    assign src_len = r_vld[src_a] ? rq_len : '0;

    assign pop_node   = r_sel ? rq_tail : rq_head;
    assign fresh      = {1'b0, r_free_head} >= r_hwm;
    assign fresh_next = (r_free_head == NA'(POOL_SIZE - 1)) ? '0 : r_free_head + 1'b1;
    assign take_next  = fresh ? fresh_next : next_rd;

    assign q_raddr = i_cmd.load_tgt ? src_a : in_q32[QA-1:0];
    assign next_ra = (r_mode == mdq_pkg::MODE_POP) ? pop_node : r_free_head;
    assign prev_ra = i_cmd.rev_step ? prev_rd : (i_cmd.load_tgt ? pop_node : rq_tail);

    always_comb begin
        q_we    = 1'b0;
        wq_head = r_dh;
        wq_tail = r_dt;
        wq_len  = r_dl;
        val_we  = 1'b0;
        next_we = 1'b0;
        next_wa = r_dt;
        next_wd = r_free_head;
        prev_we = 1'b0;
        prev_wa = r_free_head;
        prev_wd = r_dt;
        if (i_cmd.push_wr) begin
            q_we   = 1'b1;
            val_we = 1'b1;
            wq_len = r_dl + 1'b1;
            if (r_sel) begin
                wq_tail = r_free_head;
                if (r_dl == '0) begin
                    wq_head = r_free_head;
                end else begin
                    next_we = 1'b1;
                    next_wa = r_dt;
                    next_wd = r_free_head;
                    prev_we = 1'b1;
                    prev_wa = r_free_head;
                    prev_wd = r_dt;
                end
            end else begin
                wq_head = r_free_head;
                if (r_dl == '0) begin
                    wq_tail = r_free_head;
                end else begin
                    prev_we = 1'b1;
                    prev_wa = r_dh;
                    prev_wd = r_free_head;
                    next_we = 1'b1;
                    next_wa = r_free_head;
                    next_wd = r_dh;
                end
            end
        end
        if (i_cmd.pop_wr) begin
            q_we    = 1'b1;
            wq_len  = r_dl - 1'b1;
            if (r_dl > CW'(1)) begin
                if (r_sel) wq_tail = prev_rd;
                else wq_head = next_rd;
            end
            next_we = 1'b1;
            next_wa = r_node;
            next_wd = r_free_head;
        end
        if (i_cmd.cat_wr) begin
            q_we    = 1'b1;
            wq_tail = rq_tail;
            wq_len  = r_dl + src_len;
            if (r_dl == '0) begin
                wq_head = rq_head;
            end else begin
                next_we = 1'b1;
                next_wa = r_dt;
                next_wd = rq_head;
                prev_we = 1'b1;
                prev_wa = rq_head;
                prev_wd = r_dt;
            end
        end
        if (i_cmd.rev_step && r_dl != '0) begin
            next_we = 1'b1;
            next_wa = r_dt;
            next_wd = r_node;
            prev_we = 1'b1;
            prev_wa = r_node;
            prev_wd = r_dt;
        end
        if (i_cmd.fin_wr) begin
            q_we = 1'b1;
        end
    end

    mdq_ram #(.WIDTH(QEW), .DEPTH(NUM_QUEUES)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (tgt_a),
        .i_wdata ({wq_head, wq_tail, wq_len}),
        .i_raddr (q_raddr),
        .o_rdata (q_rd)
    );

    mdq_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_free_head),
        .i_wdata (r_val),
        .i_raddr (pop_node),
        .o_rdata (val_rd)
    );

    mdq_ram #(.WIDTH(NA), .DEPTH(POOL_SIZE)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_wa),
        .i_wdata (next_wd),
        .i_raddr (next_ra),
        .o_rdata (next_rd)
    );

    mdq_ram #(.WIDTH(NA), .DEPTH(POOL_SIZE)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_wa),
        .i_wdata (prev_wd),
        .i_raddr (prev_ra),
        .o_rdata (prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_q8   <= i_queue_id;
            r_o8   <= i_other_queue;
            r_sel  <= i_end_select;
            r_val  <= i_push_value;
        end
        if (i_cmd.load_tgt) begin
            r_dh   <= rq_head;
            r_dt   <= rq_tail;
            r_dl   <= tgt_len;
            r_node <= pop_node;
        end
        if (i_cmd.rev_start) begin
            r_node <= rq_tail;
            r_cnt  <= src_len;
        end
        if (i_cmd.rev_step) begin
            if (r_dl == '0) r_dh <= r_node;
            r_dt   <= r_node;
            r_dl   <= r_dl + 1'b1;
            r_node <= prev_rd;
            r_cnt  <= r_cnt - 1'b1;
        end
        if (i_cmd.res_load) begin
            r_res_st  <= i_cmd.res_code;
            r_res_val <= (i_cmd.res_code == mdq_pkg::ST_POPPED) ? val_rd : '0;
        end
        if (i_cmd.out_load) begin
            r_ost  <= r_res_st;
            r_oval <= r_res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_free_count <= CW'(POOL_SIZE);
            r_hwm        <= '0;
            r_vld        <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cmd.push_wr) begin
                r_free_head  <= take_next;
                r_free_count <= r_free_count - 1'b1;
                if (fresh) r_hwm <= r_hwm + 1'b1;
            end
            if (i_cmd.pop_wr) begin
                r_free_head  <= r_node;
                r_free_count <= r_free_count + 1'b1;
            end
            if (q_we) r_vld[tgt_a] <= 1'b1;
            if (i_cmd.cat_wr || i_cmd.rev_start) r_vld[src_a] <= 1'b0;
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.sel        = r_sel;
        o_sts.q_ok       = q_ok;
        o_sts.merge_ok   = q_ok && o_ok && (r_q8 != r_o8);
        o_sts.tgt_empty  = (tgt_len == '0);
        o_sts.pool_empty = (r_free_count == '0);
        o_sts.src_empty  = (src_len == '0);
        o_sts.last       = (r_cnt == CW'(1));
        o_sts.out_free   = !r_ov || !i_out_stall;
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_ost;
    assign o_pop_value = r_oval;

endmodule

@@ rtl/multi_deque_with_splice.sv @@
// top level of the multi deque block: controller and datapath
// depends on mdq_pkg, mdq_ctrl, mdq_dp
`timescale 1ns / 1ps

// a bank of double-ended queues over one shared pool of linked nodes.
// input channel: i_valid / o_stall carry mode, queue_id, end_select,
// push_value and other_queue. output channel: o_valid / i_stall carry
// status and pop_value, one result per pop or per push into a full pool.
// one item is worked at a time; o_stall is low only while the block idles.
// after acceptance a push runs load and push states, a pop load, pop and the
// wait for the output register (load and that wait for an empty pop or a push
// into a full pool), a merge load and source, a reversing merge also a walk of
// the source nodes and finish; each step is bounded by one registered link read.
// the output register holds a result while i_stall is high; a new item is
// still accepted, and its own result waits until the register is free.
// reset empties every queue and rebuilds the free pool at once, with no
// clearing pass: queue entries carry valid bits and never-used nodes are
// handed out by a fill count.

module multi_deque_with_splice #(
    parameter int NUM_QUEUES = mdq_pkg::NUM_QUEUES_DEF,
    parameter int POOL_SIZE  = mdq_pkg::POOL_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_queue_id,
    input  logic               i_end_select,
    input  logic signed [31:0] i_push_value,
    input  logic [7:0]         i_other_queue,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_pop_value
);

    mdq_pkg::t_cmd cmd;
    mdq_pkg::t_sts sts;

    mdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    mdq_dp #(.NUM_QUEUES(NUM_QUEUES), .POOL_SIZE(POOL_SIZE)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_queue_id    (i_queue_id),
        .i_end_select  (i_end_select),
        .i_push_value  (i_push_value),
        .i_other_queue (i_other_queue),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_pop_value   (o_pop_value)
    );

`ifndef NO_ASSERTIONS
    a_push_has_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push_wr |-> !sts.pool_empty)
        else $error("push with empty pool");

    a_value_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == mdq_pkg::ST_POPPED || o_pop_value == '0))
        else $error("nonzero value without pop");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a held result");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rev_step |-> o_stall)
        else $error("walk while idle");
`endif

endmodule
